FILE: sv/dsbc_pkg.sv
// shared types and constants for the debug step and breakpoint controller
// no dependencies
`timescale 1ns / 1ps

package dsbc_pkg;

    localparam int BP_ENTRIES   = 32;
    localparam int STEP_ENTRIES = 16;
    localparam int BP_AW   = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;
    localparam int STEP_AW = (STEP_ENTRIES > 1) ? $clog2(STEP_ENTRIES) : 1;
    localparam int BP_CW   = $clog2(BP_ENTRIES + 1);
    localparam int STEP_CW = $clog2(STEP_ENTRIES + 1);
    localparam int IDX_W   = (BP_CW > STEP_CW) ? BP_CW : STEP_CW;

    localparam int LOC_W = 64;
    localparam int ID_W  = 16;
    localparam int CMD_W = 5;

    localparam logic [CMD_W-1:0] CMD_RESET       = 5'd0;
    localparam logic [CMD_W-1:0] CMD_BREAK_START = 5'd1;
    localparam logic [CMD_W-1:0] CMD_RESUME      = 5'd2;
    localparam logic [CMD_W-1:0] CMD_CONTINUE_TO = 5'd3;
    localparam logic [CMD_W-1:0] CMD_STEP_INTO   = 5'd4;
    localparam logic [CMD_W-1:0] CMD_STEP_OVER   = 5'd5;
    localparam logic [CMD_W-1:0] CMD_STEP_OUT    = 5'd6;
    localparam logic [CMD_W-1:0] CMD_PAUSE       = 5'd7;
    localparam logic [CMD_W-1:0] CMD_ADD_STEP    = 5'd8;
    localparam logic [CMD_W-1:0] CMD_ADD_BP      = 5'd9;
    localparam logic [CMD_W-1:0] CMD_CLOSE_BP    = 5'd10;
    localparam logic [CMD_W-1:0] CMD_REMOVE_BP   = 5'd11;
    localparam logic [CMD_W-1:0] CMD_EXCEPTION   = 5'd12;
    localparam logic [CMD_W-1:0] CMD_FRAME_POP   = 5'd13;
    localparam logic [CMD_W-1:0] CMD_METHOD_ENT  = 5'd14;
    localparam logic [CMD_W-1:0] CMD_SINGLE_STEP = 5'd15;
    localparam logic [CMD_W-1:0] CMD_QUERY       = 5'd16;

    localparam logic CFG_BP_ENABLE = 1'b0;
    localparam logic CFG_EXC_MODE  = 1'b1;

    localparam logic [1:0] EXC_NEVER    = 2'd0;
    localparam logic [1:0] EXC_CAUGHT   = 2'd1;
    localparam logic [1:0] EXC_UNCAUGHT = 2'd2;
    localparam logic [1:0] EXC_ALL      = 2'd3;

    typedef enum logic [2:0] {
        MODE_NONE        = 3'd0,
        MODE_BREAK_START = 3'd1,
        MODE_CONTINUE_TO = 3'd2,
        MODE_PAUSE       = 3'd3,
        MODE_STEP_INTO   = 3'd4,
        MODE_STEP_OVER   = 3'd5,
        MODE_STEP_OUT    = 3'd6
    } mode_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic scan_done;
    } sts_t;

endpackage

FILE: sv/debug_step_breakpoint_controller.sv
// top level of the debug step and breakpoint controller
// depends on dsbc_pkg, dsbc_ctrl, dsbc_datapath and dsbc_ram
`timescale 1ns / 1ps

// a command is taken when start is high and busy is low. add_step_loc,
// remove_bp, single_step and query scan the tables one entry a cycle through
// the single read port of each table ram; other commands go straight from
// load to finish. each result shows on the result ports for one cycle with
// result_valid high and cannot be stalled; a query gives one transfer per
// match with last on the final one, or a single no-match transfer.
// configuration writes via cfg_we, cfg_index, cfg_data take effect at once
// and are meant for idle periods.
module debug_step_breakpoint_controller import dsbc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CMD_W-1:0] command,
    input  logic [LOC_W-1:0] location,
    input  logic [ID_W-1:0]  breakpoint_id,
    input  logic             uncaught,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [1:0]       cfg_data,
    output logic             result_valid,
    output logic             paused,
    output logic             first_entry,
    output logic [ID_W-1:0]  found_id,
    output logic             match_valid,
    output logic             last,
    output logic             status
);
    ctl_t ctl;
    sts_t sts;

    // sequencer: load, optional scan, finish
    dsbc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .sts     (sts),
        .ctl     (ctl),
        .busy    (busy)
    );

    // tables, mode state and result registers
    dsbc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .command       (command),
        .location      (location),
        .breakpoint_id (breakpoint_id),
        .uncaught      (uncaught),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .paused        (paused),
        .first_entry   (first_entry),
        .found_id      (found_id),
        .match_valid   (match_valid),
        .last          (last),
        .status        (status)
    );
endmodule

FILE: sv/dsbc_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dsbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: sv/dsbc_ctrl.sv
// sequencing state machine: load, table scan, finish
// depends on dsbc_pkg
`timescale 1ns / 1ps

module dsbc_ctrl import dsbc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] command,
    input  sts_t             sts,
    output ctl_t             ctl,
    output logic             busy
);
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   needs_scan;

    assign needs_scan = (command == CMD_ADD_STEP) || (command == CMD_REMOVE_BP)
                     || (command == CMD_SINGLE_STEP) || (command == CMD_QUERY);
    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = needs_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                ctl.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");
    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> !busy)
        else $error("finish not followed by idle");
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.scan && !sts.scan_done) |=> ctl.scan)
        else $error("scan left early");
endmodule

FILE: sv/dsbc_datapath.sv
// tables, step mode, flags, config registers and result registers
// depends on dsbc_pkg and dsbc_ram
`timescale 1ns / 1ps

module dsbc_datapath import dsbc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    output sts_t             sts,
    input  logic [CMD_W-1:0] command,
    input  logic [LOC_W-1:0] location,
    input  logic [ID_W-1:0]  breakpoint_id,
    input  logic             uncaught,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [1:0]       cfg_data,
    output logic             result_valid,
    output logic             paused,
    output logic             first_entry,
    output logic [ID_W-1:0]  found_id,
    output logic             match_valid,
    output logic             last,
    output logic             status
);
    // latched item
    logic [CMD_W-1:0] cmd_reg;
    logic [LOC_W-1:0] loc_reg;
    logic [ID_W-1:0]  id_reg;
    logic             unc_reg;

    // architectural state
    logic             bpen_reg, bpen_next;
    logic [1:0]       exc_reg, exc_next;
    mode_t            mode_reg, mode_next;
    logic             paused_reg, paused_next;
    logic             entered_reg, entered_next;
    logic [ID_W-1:0]  nid_reg, nid_next;
    logic [BP_CW-1:0]   bp_cnt_reg, bp_cnt_next;
    logic [STEP_CW-1:0] step_cnt_reg, step_cnt_next;

    // scan state
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             hit_bp_reg, hit_bp_next;
    logic             hit_step_reg, hit_step_next;
    logic [BP_CW-1:0] wr_ptr_reg, wr_ptr_next;
    logic             pend_reg, pend_next;
    logic [ID_W-1:0]  pend_id_reg, pend_id_next;

    // result registers
    logic             ov_reg, ov_next;
    logic             op_reg, op_next;
    logic             of_reg, of_next;
    logic [ID_W-1:0]  oid_reg, oid_next;
    logic             om_reg, om_next;
    logic             ol_reg, ol_next;
    logic             os_reg, os_next;

    // rams
    logic                    bp_we;
    logic [BP_AW-1:0]        bp_waddr;
    logic [LOC_W+ID_W-1:0]   bp_wdata, bp_rdata;
    logic                    step_we;
    logic [LOC_W-1:0]        step_rdata;
    logic                    issue;
    logic [IDX_W-1:0]        limit;
    logic                    bp_in, step_in, bp_match, step_match;

    dsbc_ram #(.WIDTH(LOC_W + ID_W), .DEPTH(BP_ENTRIES)) u_bp_ram (
        .clk   (clk),
        .we    (bp_we),
        .waddr (bp_waddr),
        .wdata (bp_wdata),
        .re    (issue),
        .raddr (idx_reg[BP_AW-1:0]),
        .rdata (bp_rdata)
    );

    dsbc_ram #(.WIDTH(LOC_W), .DEPTH(STEP_ENTRIES)) u_step_ram (
        .clk   (clk),
        .we    (step_we),
        .waddr (step_cnt_reg[STEP_AW-1:0]),
        .wdata (loc_reg),
        .re    (issue),
        .raddr (idx_reg[STEP_AW-1:0]),
        .rdata (step_rdata)
    );

    always_comb
    begin
        case (cmd_reg)
            CMD_ADD_STEP:  limit = IDX_W'(step_cnt_reg);
            CMD_SINGLE_STEP:
            begin
                if (IDX_W'(bp_cnt_reg) > IDX_W'(step_cnt_reg))
                begin
                    limit = IDX_W'(bp_cnt_reg);
                end
                else
                begin
                    limit = IDX_W'(step_cnt_reg);
                end
            end
            CMD_REMOVE_BP: limit = IDX_W'(bp_cnt_reg);
            CMD_QUERY:     limit = IDX_W'(bp_cnt_reg);
            default:       limit = '0;
        endcase
    end

    assign issue     = ctl.scan && (idx_reg < limit);
    assign bp_in     = rd_idx_reg < IDX_W'(bp_cnt_reg);
    assign step_in   = rd_idx_reg < IDX_W'(step_cnt_reg);
    assign bp_match  = bp_in && (bp_rdata[LOC_W+ID_W-1:ID_W] == loc_reg);
    assign step_match = step_in && (step_rdata == loc_reg);
    assign sts.scan_done = !issue && !rd_pend_reg;

    always_comb
    begin
        bpen_next     = bpen_reg;
        exc_next      = exc_reg;
        mode_next     = mode_reg;
        paused_next   = paused_reg;
        entered_next  = entered_reg;
        nid_next      = nid_reg;
        bp_cnt_next   = bp_cnt_reg;
        step_cnt_next = step_cnt_reg;
        idx_next      = idx_reg;
        rd_idx_next   = rd_idx_reg;
        rd_pend_next  = 1'b0;
        hit_bp_next   = hit_bp_reg;
        hit_step_next = hit_step_reg;
        wr_ptr_next   = wr_ptr_reg;
        pend_next     = pend_reg;
        pend_id_next  = pend_id_reg;
        ov_next  = 1'b0;
        op_next  = paused_reg;
        of_next  = 1'b0;
        oid_next = '0;
        om_next  = 1'b0;
        ol_next  = 1'b1;
        os_next  = 1'b0;
        bp_we    = 1'b0;
        bp_waddr = wr_ptr_reg[BP_AW-1:0];
        bp_wdata = bp_rdata;
        step_we  = 1'b0;

        if (cfg_we)
        begin
            if (cfg_index == CFG_BP_ENABLE)
            begin
                bpen_next = cfg_data[0];
            end
            else
            begin
                exc_next = cfg_data;
            end
        end

        if (ctl.load)
        begin
            idx_next      = '0;
            hit_bp_next   = 1'b0;
            hit_step_next = 1'b0;
            wr_ptr_next   = '0;
            pend_next     = 1'b0;
        end

        if (issue)
        begin
            idx_next     = idx_reg + 1'b1;
            rd_idx_next  = idx_reg;
            rd_pend_next = 1'b1;
        end

        if (rd_pend_reg)
        begin
            hit_bp_next   = hit_bp_reg | bp_match;
            hit_step_next = hit_step_reg | step_match;
            if (cmd_reg == CMD_REMOVE_BP)
            begin
                // compact survivors down to the write pointer
                if (bp_in && (bp_rdata[ID_W-1:0] != id_reg))
                begin
                    bp_we       = 1'b1;
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
            end
            if ((cmd_reg == CMD_QUERY) && bp_match)
            begin
                if (pend_reg)
                begin
                    ov_next  = 1'b1;
                    oid_next = pend_id_reg;
                    om_next  = 1'b1;
                    ol_next  = 1'b0;
                end
                pend_next    = 1'b1;
                pend_id_next = bp_rdata[ID_W-1:0];
            end
        end

        if (ctl.finish)
        begin
            ov_next = 1'b1;
            case (cmd_reg)
                CMD_RESET:
                begin
                    if (mode_reg != MODE_BREAK_START)
                    begin
                        mode_next = MODE_NONE;
                    end
                    bp_cnt_next   = '0;
                    step_cnt_next = '0;
                    entered_next  = 1'b0;
                    bpen_next     = 1'b1;
                    nid_next      = '0;
                    exc_next      = EXC_NEVER;
                end
                CMD_BREAK_START:
                begin
                    if (!paused_reg)
                    begin
                        mode_next = MODE_BREAK_START;
                    end
                end
                CMD_RESUME:
                begin
                    mode_next   = MODE_NONE;
                    paused_next = 1'b0;
                end
                CMD_CONTINUE_TO:
                begin
                    mode_next     = MODE_CONTINUE_TO;
                    step_cnt_next = '0;
                    paused_next   = 1'b0;
                end
                CMD_STEP_INTO, CMD_STEP_OVER:
                begin
                    mode_next     = (cmd_reg == CMD_STEP_INTO) ? MODE_STEP_INTO
                                                               : MODE_STEP_OVER;
                    entered_next  = 1'b0;
                    step_cnt_next = '0;
                    paused_next   = 1'b0;
                end
                CMD_STEP_OUT:
                begin
                    mode_next    = MODE_STEP_OUT;
                    entered_next = 1'b1;
                    paused_next  = 1'b0;
                end
                CMD_PAUSE:
                begin
                    if (!paused_reg)
                    begin
                        mode_next = MODE_PAUSE;
                    end
                end
                CMD_ADD_STEP:
                begin
                    if (!hit_step_reg)
                    begin
                        if (step_cnt_reg < STEP_CW'(STEP_ENTRIES))
                        begin
                            step_we       = 1'b1;
                            step_cnt_next = step_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            os_next = 1'b1;
                        end
                    end
                end
                CMD_ADD_BP:
                begin
                    if (bp_cnt_reg < BP_CW'(BP_ENTRIES))
                    begin
                        bp_we       = 1'b1;
                        bp_waddr    = bp_cnt_reg[BP_AW-1:0];
                        bp_wdata    = {loc_reg, nid_reg};
                        bp_cnt_next = bp_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        os_next = 1'b1;
                    end
                end
                CMD_CLOSE_BP:
                begin
                    oid_next = nid_reg;
                    nid_next = nid_reg + 1'b1;
                end
                CMD_REMOVE_BP:
                begin
                    bp_cnt_next = wr_ptr_reg;
                end
                CMD_EXCEPTION:
                begin
                    case (exc_reg)
                        EXC_CAUGHT:   paused_next = !unc_reg;
                        EXC_UNCAUGHT: paused_next = unc_reg;
                        EXC_ALL:      paused_next = 1'b1;
                        default:      paused_next = paused_reg;
                    endcase
                end
                CMD_FRAME_POP:
                begin
                    if ((mode_reg == MODE_STEP_OUT) || (mode_reg == MODE_STEP_OVER))
                    begin
                        entered_next = 1'b0;
                    end
                end
                CMD_METHOD_ENT:
                begin
                    if ((mode_reg == MODE_STEP_OUT) || (mode_reg == MODE_STEP_OVER))
                    begin
                        of_next      = !entered_reg;
                        entered_next = 1'b1;
                    end
                end
                CMD_SINGLE_STEP:
                begin
                    if (bpen_reg && hit_bp_reg)
                    begin
                        paused_next = 1'b1;
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_BREAK_START, MODE_PAUSE: paused_next = 1'b1;
                            MODE_CONTINUE_TO: paused_next = hit_step_reg;
                            MODE_STEP_INTO:   paused_next = !hit_step_reg;
                            MODE_STEP_OUT:    paused_next = !entered_reg;
                            MODE_STEP_OVER:   paused_next = !entered_reg && !hit_step_reg;
                            default:          paused_next = 1'b0;
                        endcase
                    end
                end
                CMD_QUERY:
                begin
                    oid_next = pend_reg ? pend_id_reg : '0;
                    om_next  = pend_reg;
                end
                default:
                begin
                    ov_next = 1'b1;
                end
            endcase
            op_next = paused_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpen_reg     <= 1'b1;
            exc_reg      <= EXC_NEVER;
            mode_reg     <= MODE_NONE;
            paused_reg   <= 1'b0;
            entered_reg  <= 1'b0;
            nid_reg      <= '0;
            bp_cnt_reg   <= '0;
            step_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            bpen_reg     <= bpen_next;
            exc_reg      <= exc_next;
            mode_reg     <= mode_next;
            paused_reg   <= paused_next;
            entered_reg  <= entered_next;
            nid_reg      <= nid_next;
            bp_cnt_reg   <= bp_cnt_next;
            step_cnt_reg <= step_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= command;
            loc_reg <= location;
            id_reg  <= breakpoint_id;
            unc_reg <= uncaught;
        end
        idx_reg      <= idx_next;
        rd_idx_reg   <= rd_idx_next;
        hit_bp_reg   <= hit_bp_next;
        hit_step_reg <= hit_step_next;
        wr_ptr_reg   <= wr_ptr_next;
        pend_reg     <= pend_next;
        pend_id_reg  <= pend_id_next;
        op_reg  <= op_next;
        of_reg  <= of_next;
        oid_reg <= oid_next;
        om_reg  <= om_next;
        ol_reg  <= ol_next;
        os_reg  <= os_next;
    end

    assign result_valid = ov_reg;
    assign paused       = op_reg;
    assign first_entry  = of_reg;
    assign found_id     = oid_reg;
    assign match_valid  = om_reg;
    assign last         = ol_reg;
    assign status       = os_reg;

    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(ctl.finish) || $past(ctl.scan)))
        else $error("result without scan or finish");
    a_bp_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bp_cnt_reg <= BP_CW'(BP_ENTRIES))
        else $error("breakpoint count beyond table");
    a_step_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_cnt_reg <= STEP_CW'(STEP_ENTRIES))
        else $error("step count beyond table");
endmodule

FILE: bench/debug_step_breakpoint_controller_tb.sv
// self-checking bench for the debug step and breakpoint controller
// holds its own model of the mode, paused flag and both location tables
// depends on dsbc_pkg and debug_step_breakpoint_controller
`timescale 1ns / 1ps

module debug_step_breakpoint_controller_tb;
    import dsbc_pkg::*;

    // one command as sent to the block
    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [LOC_W-1:0] loc;
        logic [ID_W-1:0]  bid;
        logic             unc;
    } cmd_item_t;

    // one result transfer as expected from the block
    typedef struct {
        logic            paused;
        logic            first_entry;
        logic [ID_W-1:0] found_id;
        logic            match_valid;
        logic            last;
        logic            status;
    } debug_result_t;

    localparam int MAX_MATCHES = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [CMD_W-1:0] command;
    logic [LOC_W-1:0] location;
    logic [ID_W-1:0]  breakpoint_id;
    logic             uncaught;
    logic             cfg_we;
    logic             cfg_index;
    logic [1:0]       cfg_data;
    logic             result_valid;
    logic             paused;
    logic             first_entry;
    logic [ID_W-1:0]  found_id;
    logic             match_valid;
    logic             last;
    logic             status;

    debug_step_breakpoint_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .location     (location),
        .breakpoint_id(breakpoint_id),
        .uncaught     (uncaught),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .paused       (paused),
        .first_entry  (first_entry),
        .found_id     (found_id),
        .match_valid  (match_valid),
        .last         (last),
        .status       (status)
    );

    // predictor copy of the block state
    logic            bp_en;
    logic [1:0]      exc_mode;
    mode_t           mode;
    logic            is_paused;
    logic            entered;
    logic [ID_W-1:0] id_counter;
    logic [LOC_W-1:0] bp_loc_tbl [BP_ENTRIES];
    logic [ID_W-1:0]  bp_id_tbl  [BP_ENTRIES];
    int               bp_fill;
    logic [LOC_W-1:0] step_loc_tbl [STEP_ENTRIES];
    int               step_fill;

    cmd_item_t     pending_cmds[$];
    debug_result_t expected_results[$];

    int  mismatches;
    int  transfers_seen;
    int  cmds_sent;
    int  cycles;

    // configuration writes happen only while the driver is held off
    bit  cfg_hold;

    // stimulus location pool so that locations repeat and tables get hits
    logic [LOC_W-1:0] loc_pool [8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    function automatic bit step_table_has(input logic [LOC_W-1:0] l);
        for (int i = 0; i < step_fill; i++)
            if (step_loc_tbl[i] == l)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit bp_table_has(input logic [LOC_W-1:0] l);
        for (int i = 0; i < bp_fill; i++)
            if (bp_loc_tbl[i] == l)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void reset_model();
        bp_en      = 1'b1;
        exc_mode   = EXC_NEVER;
        mode       = MODE_NONE;
        is_paused  = 1'b0;
        entered    = 1'b0;
        id_counter = '0;
        bp_fill    = 0;
        step_fill  = 0;
    endfunction

    function automatic void push_result(input logic fe, input logic [ID_W-1:0] fid,
                                        input logic mv, input logic lst,
                                        input logic st);
        debug_result_t r;
        r.paused = is_paused;
        r.first_entry = fe;
        r.found_id = fid;
        r.match_valid = mv;
        r.last = lst;
        r.status = st;
        expected_results.push_back(r);
    endfunction

    // computes the transfers one accepted command causes
    function automatic void predict_command(input cmd_item_t c);
        logic            fe;
        logic [ID_W-1:0] fid;
        logic            st;
        int              w;
        int              hits;
        fe = 1'b0;
        fid = '0;
        st = 1'b0;
        case (c.cmd)
            CMD_RESET:
            begin
                if (mode != MODE_BREAK_START)
                    mode = MODE_NONE;
                bp_fill = 0;
                step_fill = 0;
                entered = 1'b0;
                bp_en = 1'b1;
                id_counter = '0;
                exc_mode = EXC_NEVER;
            end
            CMD_BREAK_START: if (!is_paused) mode = MODE_BREAK_START;
            CMD_RESUME:
            begin
                mode = MODE_NONE;
                is_paused = 1'b0;
            end
            CMD_CONTINUE_TO:
            begin
                mode = MODE_CONTINUE_TO;
                step_fill = 0;
                is_paused = 1'b0;
            end
            CMD_STEP_INTO, CMD_STEP_OVER:
            begin
                mode = (c.cmd == CMD_STEP_INTO) ? MODE_STEP_INTO : MODE_STEP_OVER;
                entered = 1'b0;
                step_fill = 0;
                is_paused = 1'b0;
            end
            CMD_STEP_OUT:
            begin
                mode = MODE_STEP_OUT;
                entered = 1'b1;
                is_paused = 1'b0;
            end
            CMD_PAUSE: if (!is_paused) mode = MODE_PAUSE;
            CMD_ADD_STEP:
            begin
                if (!step_table_has(c.loc))
                begin
                    if (step_fill < STEP_ENTRIES)
                    begin
                        step_loc_tbl[step_fill] = c.loc;
                        step_fill++;
                    end
                    else
                        st = 1'b1;
                end
            end
            CMD_ADD_BP:
            begin
                if (bp_fill < BP_ENTRIES)
                begin
                    bp_loc_tbl[bp_fill] = c.loc;
                    bp_id_tbl[bp_fill] = id_counter;
                    bp_fill++;
                end
                else
                    st = 1'b1;
            end
            CMD_CLOSE_BP:
            begin
                fid = id_counter;
                id_counter = id_counter + 1'b1;
            end
            CMD_REMOVE_BP:
            begin
                // compact the table keeping insertion order
                w = 0;
                for (int r = 0; r < bp_fill; r++)
                begin
                    if (bp_id_tbl[r] != c.bid)
                    begin
                        bp_loc_tbl[w] = bp_loc_tbl[r];
                        bp_id_tbl[w] = bp_id_tbl[r];
                        w++;
                    end
                end
                bp_fill = w;
            end
            CMD_EXCEPTION:
            begin
                case (exc_mode)
                    EXC_CAUGHT:   is_paused = !c.unc;
                    EXC_UNCAUGHT: is_paused = c.unc;
                    EXC_ALL:      is_paused = 1'b1;
                    default:      ;
                endcase
            end
            CMD_FRAME_POP:
                if (mode == MODE_STEP_OUT || mode == MODE_STEP_OVER)
                    entered = 1'b0;
            CMD_METHOD_ENT:
            begin
                if (mode == MODE_STEP_OUT || mode == MODE_STEP_OVER)
                begin
                    fe = !entered;
                    entered = 1'b1;
                end
            end
            CMD_SINGLE_STEP:
            begin
                if (bp_en && bp_table_has(c.loc))
                    is_paused = 1'b1;
                else
                begin
                    case (mode)
                        MODE_BREAK_START, MODE_PAUSE: is_paused = 1'b1;
                        MODE_CONTINUE_TO: is_paused = step_table_has(c.loc);
                        MODE_STEP_INTO:   is_paused = !step_table_has(c.loc);
                        MODE_STEP_OUT:    is_paused = !entered;
                        MODE_STEP_OVER:
                            is_paused = !entered && !step_table_has(c.loc);
                        default:          is_paused = 1'b0;
                    endcase
                end
            end
            CMD_QUERY:
            begin
                hits = 0;
                for (int i = 0; i < bp_fill && hits < MAX_MATCHES; i++)
                begin
                    if (bp_loc_tbl[i] == c.loc)
                    begin
                        push_result(1'b0, bp_id_tbl[i], 1'b1, 1'b0, 1'b0);
                        hits++;
                    end
                end
                if (hits == 0)
                    push_result(1'b0, '0, 1'b0, 1'b1, 1'b0);
                else
                    expected_results[$].last = 1'b1;
                return;
            end
            default: ;
        endcase
        push_result(fe, fid, 1'b0, 1'b1, st);
    endfunction

    function automatic logic [LOC_W-1:0] pick_loc();
        if ($urandom_range(0, 9) < 8)
            return loc_pool[$urandom_range(0, 7)];
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_cmd(input logic [CMD_W-1:0] cmd,
                                      input logic [LOC_W-1:0] l,
                                      input logic [ID_W-1:0] b, input logic u);
        cmd_item_t c;
        c.cmd = cmd;
        c.loc = l;
        c.bid = b;
        c.unc = u;
        pending_cmds.push_back(c);
    endfunction

    // random command with a bias toward table traffic and stepping events
    function automatic void queue_random_cmd();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 2)
            queue_cmd(CMD_RESET, pick_loc(), ID_W'($urandom), 1'($urandom));
        else if (sel < 3)
            // unused codes, all five bits exercised
            queue_cmd(CMD_W'($urandom_range(17, 31)), pick_loc(), ID_W'($urandom),
                      1'($urandom));
        else if (sel < 20)
            queue_cmd(CMD_W'($urandom_range(1, 7)), pick_loc(), ID_W'($urandom),
                      1'($urandom));
        else if (sel < 32)
            queue_cmd(CMD_ADD_STEP, pick_loc(), ID_W'($urandom), 1'($urandom));
        else if (sel < 46)
            queue_cmd(CMD_ADD_BP, pick_loc(), ID_W'($urandom), 1'($urandom));
        else if (sel < 52)
            queue_cmd(CMD_CLOSE_BP, pick_loc(), ID_W'($urandom), 1'($urandom));
        else if (sel < 57)
            queue_cmd(CMD_REMOVE_BP, pick_loc(),
                      ($urandom_range(0, 3) == 0) ? ID_W'($urandom)
                                                  : ID_W'($urandom_range(0, 6)),
                      1'($urandom));
        else if (sel < 64)
            queue_cmd(CMD_EXCEPTION, pick_loc(), ID_W'($urandom), 1'($urandom));
        else if (sel < 78)
            queue_cmd(CMD_W'($urandom_range(13, 14)), pick_loc(), ID_W'($urandom),
                      1'($urandom));
        else if (sel < 92)
            queue_cmd(CMD_SINGLE_STEP, pick_loc(), ID_W'($urandom), 1'($urandom));
        else
            queue_cmd(CMD_QUERY, pick_loc(), ID_W'($urandom), 1'($urandom));
    endfunction

    // no gap or a short one mostly, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver state
    int  drv_gap;
    cmd_item_t drv_cur;
    bit start_pend;

    // a transfer happens when start && !busy at posedge
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            predict_command(drv_cur);
            cmds_sent++;
            start_pend = 1'b0;
        end
    end

    // driver: one command at a time, changes on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (!start_pend && !cfg_hold)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (pending_cmds.size() > 0)
                begin
                    drv_cur = pending_cmds.pop_front();
                    command <= drv_cur.cmd;
                    location <= drv_cur.loc;
                    breakpoint_id <= drv_cur.bid;
                    uncaught <= drv_cur.unc;
                    start_pend = 1'b1;
                    drv_gap = gap_len();
                end
            end
            start <= start_pend;
        end
    end

    // monitor: compares each transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            debug_result_t want;
            transfers_seen++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected transfer", '0, '0);
            else
            begin
                want = expected_results.pop_front();
                if (paused !== want.paused)
                    report_mismatch("paused", 64'(paused), 64'(want.paused));
                if (first_entry !== want.first_entry)
                    report_mismatch("first_entry", 64'(first_entry),
                                    64'(want.first_entry));
                if (found_id !== want.found_id)
                    report_mismatch("found_id", 64'(found_id), 64'(want.found_id));
                if (match_valid !== want.match_valid)
                    report_mismatch("match_valid", 64'(match_valid),
                                    64'(want.match_valid));
                if (last !== want.last)
                    report_mismatch("last", 64'(last), 64'(want.last));
                if (status !== want.status)
                    report_mismatch("status", 64'(status), 64'(want.status));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || start_pend || expected_results.size() > 0)
            @(posedge clk);
        // let any scan in progress wind down
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BP_ENABLE)
            bp_en = val[0];
        else
            exc_mode = val;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_RESET;
        location = '0;
        breakpoint_id = '0;
        uncaught = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BP_ENABLE;
        cfg_data = '0;
        cfg_hold = 1'b1;
        start_pend = 1'b0;
        drv_gap = 0;
        mismatches = 0;
        transfers_seen = 0;
        cmds_sent = 0;
        cycles = 0;
        reset_model();
        loc_pool[0] = '0;
        loc_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            loc_pool[i] = {32'($urandom_range(0, 3)), 32'($urandom_range(0, 15))};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part: every command, field extremes, full tables
        write_cfg(CFG_EXC_MODE, EXC_ALL);
        cfg_hold = 1'b0;
        queue_cmd(CMD_PAUSE, '0, '0, 1'b0);
        queue_cmd(CMD_SINGLE_STEP, '1, '1, 1'b1);
        queue_cmd(CMD_PAUSE, '0, '0, 1'b0);
        queue_cmd(CMD_BREAK_START, '0, '0, 1'b0);
        queue_cmd(CMD_RESUME, '0, '0, 1'b0);
        queue_cmd(CMD_EXCEPTION, '0, '0, 1'b1);
        queue_cmd(CMD_CONTINUE_TO, '0, '0, 1'b0);
        queue_cmd(CMD_ADD_STEP, '1, '0, 1'b0);
        queue_cmd(CMD_ADD_STEP, '1, '0, 1'b0);
        queue_cmd(CMD_SINGLE_STEP, '1, '0, 1'b0);
        queue_cmd(CMD_STEP_OVER, '0, '0, 1'b0);
        queue_cmd(CMD_METHOD_ENT, '0, '0, 1'b0);
        queue_cmd(CMD_METHOD_ENT, '0, '0, 1'b0);
        queue_cmd(CMD_FRAME_POP, '0, '0, 1'b0);
        queue_cmd(CMD_STEP_OUT, '0, '0, 1'b0);
        queue_cmd(CMD_SINGLE_STEP, '0, '0, 1'b0);
        queue_cmd(CMD_STEP_INTO, '0, '0, 1'b0);
        queue_cmd(CMD_CLOSE_BP, '0, '0, 1'b0);
        queue_cmd(CMD_QUERY, '1, '0, 1'b0);
        queue_cmd(CMD_REMOVE_BP, '0, '1, 1'b0);
        queue_cmd(5'd31, '0, '0, 1'b0);
        // fill the step set and the breakpoint table past capacity
        for (int i = 0; i <= STEP_ENTRIES; i++)
            queue_cmd(CMD_ADD_STEP, {32'd9, 32'(i)}, '0, 1'b0);
        for (int i = 0; i <= BP_ENTRIES; i++)
            queue_cmd(CMD_ADD_BP, '1, '0, 1'b0);
        queue_cmd(CMD_QUERY, '1, '0, 1'b0);
        queue_cmd(CMD_SINGLE_STEP, '1, '0, 1'b0);
        queue_cmd(CMD_REMOVE_BP, '0, '0, 1'b0);
        queue_cmd(CMD_RESET, '0, '0, 1'b0);

        // random phases with a different register setting each
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            cfg_hold = 1'b1;
            write_cfg(CFG_BP_ENABLE, {1'b0, phase[0]});
            write_cfg(CFG_EXC_MODE, phase[2:1] ^ 2'(phase >> 2));
            cfg_hold = 1'b0;
            for (int k = 0; k < 42; k++)
                queue_random_cmd();
            // a few extra closes so that later ids get used
            if (phase == 5)
                for (int k = 0; k < 4; k++)
                    queue_cmd(CMD_CLOSE_BP, '0, '0, 1'b0);
        end
        wait_idle();

        $display("sent %0d commands, checked %0d result transfers", cmds_sent,
                 transfers_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
sv/dsbc_pkg.sv
sv/dsbc_ram.sv
sv/dsbc_ctrl.sv
sv/dsbc_datapath.sv
sv/debug_step_breakpoint_controller.sv
bench/debug_step_breakpoint_controller_tb.sv
